// ===== hw/rtl/nmea_gga_sentence_parser_defines.svh =====
// ----------------------------------------------------------------------------
// NMEA GGA parser assertion macros
// Shared property shapes for the concurrent checks of the parser modules.
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_GGA_SENTENCE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nmea gga parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define NGP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nmea gga parser check failed");

`endif

// ===== hw/rtl/nmeagga_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA parser package
// Result type, header bytes, character codes and the time conversion.
// ----------------------------------------------------------------------------
package nmeagga_pkg;

  localparam int unsigned HDR_LEN  = 6;
  localparam int unsigned TIME_LEN = 6;

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_G       = 8'h47;
  localparam logic [7:0] CHAR_N       = 8'h4E;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [3:0] LAT_FIELD = 4'd1;
  localparam logic [3:0] LON_FIELD = 4'd3;
  localparam int unsigned LOCK_MIN_CHARS = 8;

  // Offset of two ASCII digits combined as ten times the first plus the second.
  localparam logic [12:0] DIGIT_PAIR_OFFSET = 13'd528;

  typedef struct packed {
    logic              char_valid;
    logic [3:0]        field_index;
    logic [3:0]        char_position;
    logic [7:0]        character;
    logic              sentence_done;
    logic              lock;
    logic signed [12:0] hour;
    logic signed [12:0] minute;
    logic signed [12:0] second;
  } result_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CHAR_DOLLAR;
      3'd1:    b = CHAR_G;
      3'd2:    b = CHAR_N;
      3'd3:    b = CHAR_G;
      3'd4:    b = CHAR_G;
      3'd5:    b = CHAR_A;
      default: b = CHAR_DOLLAR;
    endcase
    return b;
  endfunction

  function automatic logic signed [12:0] two_digit(input logic [7:0] hi,
                                                   input logic [7:0] lo);
    logic [12:0] h;
    logic [12:0] l;
    h = {5'd0, hi};
    l = {5'd0, lo};
    return $signed((h << 3) + (h << 1) + l - DIGIT_PAIR_OFFSET);
  endfunction

endpackage

// ===== hw/rtl/nmeagga_core.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA parser core
// Sentence state and the one-word update that forms each result.
// ----------------------------------------------------------------------------
`include "nmea_gga_sentence_parser_defines.svh"

module nmeagga_core #(
  parameter int unsigned MAX_FIELD_CHARS = 16,
  parameter int unsigned NUM_FIELDS      = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           rx_byte,
  output nmeagga_pkg::result_t result
);

  localparam int unsigned CW = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_FIELD_CHARS);
  localparam logic [CW-1:0] LOCK_C = CW'(nmeagga_pkg::LOCK_MIN_CHARS);
  localparam logic [3:0]    NF_C   = 4'(NUM_FIELDS);
  localparam logic [2:0]    HDR_C  = 3'(nmeagga_pkg::HDR_LEN);

  logic [2:0]    header_matched_r, header_matched_nxt;
  logic          in_body_r, in_body_nxt;
  logic          skip_pending_r, skip_pending_nxt;
  logic [3:0]    fields_closed_r, fields_closed_nxt;
  logic [CW-1:0] chars_in_field_r, chars_in_field_nxt;
  logic          lock_flag_r, lock_flag_nxt;
  logic [7:0]    time_digits_r [nmeagga_pkg::TIME_LEN];
  logic [7:0]    time_digits_nxt [nmeagga_pkg::TIME_LEN];

  always_comb begin
    header_matched_nxt = header_matched_r;
    in_body_nxt        = in_body_r;
    skip_pending_nxt   = skip_pending_r;
    fields_closed_nxt  = fields_closed_r;
    chars_in_field_nxt = chars_in_field_r;
    lock_flag_nxt      = lock_flag_r;
    for (int p = 0; p < nmeagga_pkg::TIME_LEN; p++) begin
      time_digits_nxt[p] = time_digits_r[p];
    end
    result = '0;

    priority if (!in_body_r) begin
      if (header_matched_r < HDR_C &&
          rx_byte == nmeagga_pkg::hdr_byte(header_matched_r)) begin
        header_matched_nxt = header_matched_r + 3'd1;
        if (header_matched_r == HDR_C - 3'd1) begin
          in_body_nxt        = 1'b1;
          skip_pending_nxt   = 1'b1;
          fields_closed_nxt  = '0;
          chars_in_field_nxt = '0;
        end
      end else begin
        header_matched_nxt = '0;
      end
    end else if (rx_byte == nmeagga_pkg::CHAR_NEWLINE) begin
      result.sentence_done = 1'b1;
      result.hour   = nmeagga_pkg::two_digit(time_digits_r[0], time_digits_r[1]);
      result.minute = nmeagga_pkg::two_digit(time_digits_r[2], time_digits_r[3]);
      result.second = nmeagga_pkg::two_digit(time_digits_r[4], time_digits_r[5]);
      in_body_nxt        = 1'b0;
      skip_pending_nxt   = 1'b0;
      header_matched_nxt = '0;
      fields_closed_nxt  = '0;
      chars_in_field_nxt = '0;
    end else if (skip_pending_r) begin
      skip_pending_nxt = 1'b0;
    end else if (fields_closed_r < NF_C) begin
      if (rx_byte == nmeagga_pkg::CHAR_COMMA) begin
        if (fields_closed_r == nmeagga_pkg::LAT_FIELD ||
            fields_closed_r == nmeagga_pkg::LON_FIELD) begin
          if (chars_in_field_r == '0) begin
            lock_flag_nxt = 1'b0;
          end else if (chars_in_field_r >= LOCK_C) begin
            lock_flag_nxt = 1'b1;
          end
        end
        chars_in_field_nxt = '0;
        fields_closed_nxt  = fields_closed_r + 4'd1;
      end else if (chars_in_field_r < MAX_C) begin
        if (fields_closed_r == 4'd0) begin
          for (int p = 0; p < nmeagga_pkg::TIME_LEN; p++) begin
            if (chars_in_field_r == CW'(p)) begin
              time_digits_nxt[p] = rx_byte;
            end else if (p > 0 && chars_in_field_r == CW'(p - 1)) begin
              time_digits_nxt[p] = 8'd0;
            end
          end
        end
        result.char_valid    = 1'b1;
        result.field_index   = fields_closed_r;
        result.char_position = chars_in_field_r[3:0];
        result.character     = rx_byte;
        chars_in_field_nxt   = chars_in_field_r + CW'(1);
      end
    end else begin
      // Bytes after the last field are dropped until the newline.
      skip_pending_nxt = skip_pending_r;
    end

    result.lock = lock_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_matched_r <= '0;
      in_body_r        <= 1'b0;
      skip_pending_r   <= 1'b0;
      fields_closed_r  <= '0;
      chars_in_field_r <= '0;
      lock_flag_r      <= 1'b0;
      for (int p = 0; p < nmeagga_pkg::TIME_LEN; p++) begin
        time_digits_r[p] <= '0;
      end
    end else if (fire) begin
      header_matched_r <= header_matched_nxt;
      in_body_r        <= in_body_nxt;
      skip_pending_r   <= skip_pending_nxt;
      fields_closed_r  <= fields_closed_nxt;
      chars_in_field_r <= chars_in_field_nxt;
      lock_flag_r      <= lock_flag_nxt;
      for (int p = 0; p < nmeagga_pkg::TIME_LEN; p++) begin
        time_digits_r[p] <= time_digits_nxt[p];
      end
    end
  end

  `NGP_ASSERT_SAME(a_body_hdr_full, clk, rst_n, in_body_r, header_matched_r == HDR_C)
  `NGP_ASSERT_SAME(a_hunt_hdr_short, clk, rst_n, !in_body_r, header_matched_r < HDR_C)
  `NGP_ASSERT_SAME(a_skip_in_body, clk, rst_n, skip_pending_r, in_body_r)
  `NGP_ASSERT_SAME(a_fields_bound, clk, rst_n, 1'b1, fields_closed_r <= NF_C)
  `NGP_ASSERT_SAME(a_chars_bound, clk, rst_n, 1'b1, chars_in_field_r <= MAX_C)

endmodule

// ===== hw/rtl/nmeagga_out_stage.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA parser result register
// Holds one result word and presents it on the master stream side.
// ----------------------------------------------------------------------------
`include "nmea_gga_sentence_parser_defines.svh"

module nmeagga_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  nmeagga_pkg::result_t result,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);

  logic                 valid_r;
  nmeagga_pkg::result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.second, data_r.minute, data_r.hour, data_r.lock,
                       data_r.character, data_r.char_position, data_r.field_index};
  assign out_tlast  = data_r.sentence_done;
  assign out_tuser  = data_r.char_valid;

  `NGP_ASSERT_SAME(a_char_not_done, clk, rst_n, out_tvalid && out_tuser, !out_tlast)
  `NGP_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_tvalid)
  `NGP_ASSERT_SAME(a_no_overwrite, clk, rst_n, valid_r && !out_tready, !load)

endmodule

// ===== hw/rtl/nmea_gga_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA sentence parser
// Channel   Dir  Word
// in_*      in   tdata[7:0] received byte
// out_*     out  tdata field/position/character/lock/hour/minute/second,
//                tlast sentence done, tuser character stored
// Every byte yields one result word, one word per cycle sustained while the
// output is not stalled: an input register, the parser update, a result register.
// Synchronous active-low reset clears the hunt, field counters, lock and time.
// A stalled result register holds its word and stalls the input side.
// ----------------------------------------------------------------------------
`include "nmea_gga_sentence_parser_defines.svh"

module nmea_gga_sentence_parser #(
  parameter int unsigned MAX_FIELD_CHARS = 16,
  parameter int unsigned NUM_FIELDS      = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // field_index[3:0], char_position[7:4], character[15:8], lock[16],
  // hour[29:17], minute[42:30], second[55:43]
  output logic [55:0] out_tdata,
  output logic        out_tlast,  // sentence_done
  output logic        out_tuser   // char_valid
);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 out_free;
  logic                 advance;
  nmeagga_pkg::result_t result;

  assign out_free  = !out_tvalid || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  nmeagga_core #(
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS),
    .NUM_FIELDS      (NUM_FIELDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .rx_byte (in_byte_r),
    .result  (result)
  );

  nmeagga_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `NGP_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_valid_r && !advance, in_valid_r)
  `NGP_ASSERT_NEXT(a_byte_holds, clk, rst_n, in_valid_r && !advance, $stable(in_byte_r))
  `NGP_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !in_valid_r, in_tready)

endmodule

// ===== tb/nmea_gga_sentence_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA GGA sentence parser testbench
// Streams received bytes into the parser and checks every result word
// against the directed table's expected word or an in-bench model of the
// header hunt, field split, lock flag and time conversion. A short table of
// directed bytes comes first, followed by randomised sentences, broken
// sentences and noise with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module nmea_gga_sentence_parser_test;

  localparam int unsigned MAX_FIELD_CHARS = 16;
  localparam int unsigned NUM_FIELDS      = 9;
  localparam int          RANDOM_BYTES    = 1400;
  localparam int          CYCLE_LIMIT     = 600000;
  localparam int          DIR_ROWS        = 24;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;
  localparam logic signed [12:0] NO_DIGITS = -13'sd528;

  typedef struct {
    logic [7:0]         rx;
    bit                 typed;
    bit                 done;
    bit                 lock;
    logic signed [12:0] hour;
    logic signed [12:0] minute;
    logic signed [12:0] second;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // field_index[3:0], char_position[7:4], character[15:8], lock[16],
  // hour[29:17], minute[42:30], second[55:43]
  logic [55:0] out_tdata;
  logic        out_tlast;  // sentence_done
  logic        out_tuser;  // char_valid

  nmea_gga_sentence_parser #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS),
    .NUM_FIELDS     (NUM_FIELDS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  logic [7:0] header_seq [nmeagga_pkg::HDR_LEN] = '{
    nmeagga_pkg::CHAR_DOLLAR, nmeagga_pkg::CHAR_G, nmeagga_pkg::CHAR_N,
    nmeagga_pkg::CHAR_G, nmeagga_pkg::CHAR_G, nmeagga_pkg::CHAR_A
  };

  // Parser model state.
  logic [2:0] hdr_count   = '0;
  bit         body_open   = 1'b0;
  bit         skip_next   = 1'b0;
  logic [3:0] commas_seen = '0;
  logic [4:0] field_len   = '0;
  bit         pos_lock    = 1'b0;
  logic [7:0] time_chars [nmeagga_pkg::TIME_LEN] = '{default: 8'h00};

  nmeagga_pkg::result_t pending_words [$];
  int      mismatch_count = 0;
  int      bytes_sent     = 0;
  int      cycle_count    = 0;
  int      tx_calm_left   = 0;
  int      rx_calm_left   = 0;
  int      rx_stall_left  = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00,                     1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{8'hFF,                     1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_DOLLAR,  1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{8'h58,                     1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_DOLLAR,  1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_N,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_A,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_NEWLINE, 1, 1, 0, NO_DIGITS, NO_DIGITS, NO_DIGITS},
    '{nmeagga_pkg::CHAR_DOLLAR,  1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_N,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_G,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_A,       1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_COMMA,   1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{8'h31,                     0, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{8'h32,                     0, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_COMMA,   1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_COMMA,   1, 0, 0, 13'sd0,  13'sd0,    13'sd0},
    '{nmeagga_pkg::CHAR_NEWLINE, 1, 1, 0, 13'sd12, NO_DIGITS, NO_DIGITS}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [12:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    int v;
    v = (int'(hi) - int'(ASCII_ZERO)) * 10 + (int'(lo) - int'(ASCII_ZERO));
    return v[12:0];
  endfunction

  function automatic nmeagga_pkg::result_t parse_gga_byte(input logic [7:0] b);
    nmeagga_pkg::result_t w;
    w = '0;
    if (!body_open) begin
      if (hdr_count < nmeagga_pkg::HDR_LEN && b == header_seq[hdr_count]) begin
        hdr_count++;
        if (hdr_count == nmeagga_pkg::HDR_LEN) begin
          body_open   = 1'b1;
          skip_next   = 1'b1;
          commas_seen = '0;
          field_len   = '0;
        end
      end else begin
        hdr_count = '0;
      end
    end else if (b == nmeagga_pkg::CHAR_NEWLINE) begin
      w.sentence_done = 1'b1;
      w.hour   = pair_value(time_chars[0], time_chars[1]);
      w.minute = pair_value(time_chars[2], time_chars[3]);
      w.second = pair_value(time_chars[4], time_chars[5]);
      body_open   = 1'b0;
      skip_next   = 1'b0;
      hdr_count   = '0;
      commas_seen = '0;
      field_len   = '0;
    end else if (skip_next) begin
      skip_next = 1'b0;
    end else if (commas_seen < NUM_FIELDS) begin
      if (b == nmeagga_pkg::CHAR_COMMA) begin
        if (commas_seen == nmeagga_pkg::LAT_FIELD ||
            commas_seen == nmeagga_pkg::LON_FIELD) begin
          if (field_len == 0) begin
            pos_lock = 1'b0;
          end else if (field_len >= nmeagga_pkg::LOCK_MIN_CHARS) begin
            pos_lock = 1'b1;
          end
        end
        field_len = '0;
        commas_seen++;
      end else if (field_len < MAX_FIELD_CHARS) begin
        // Storing a time character clears the next one as an end marker.
        if (commas_seen == 0) begin
          if (field_len < nmeagga_pkg::TIME_LEN) time_chars[field_len] = b;
          if (field_len + 1 < nmeagga_pkg::TIME_LEN) time_chars[field_len + 1] = 8'h00;
        end
        w.char_valid    = 1'b1;
        w.field_index   = commas_seen;
        w.char_position = field_len[3:0];
        w.character     = b;
        field_len++;
      end
    end
    w.lock = pos_lock;
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic int tx_gap();
    int roll;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      tx_calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 70) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input nmeagga_pkg::result_t typed_word);
    int                   gap;
    nmeagga_pkg::result_t w;
    gap = tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) begin
        in_tdata <= 8'($urandom_range(0, 255));
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    w = parse_gga_byte(b);
    pending_words.push_back(typed ? typed_word : w);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] field_char();
    int         roll;
    logic [7:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      c = ASCII_ZERO + 8'($urandom_range(0, 9));
    end else if (roll < 90) begin
      c = ASCII_DOT;
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == nmeagga_pkg::CHAR_COMMA || c == nmeagga_pkg::CHAR_NEWLINE);
    end
    return c;
  endfunction

  task automatic send_field(input int idx);
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (idx == 0 && roll < 40) n = nmeagga_pkg::TIME_LEN;
    else if (roll < 15) n = 0;
    else if (roll < 80) n = $urandom_range(1, 10);
    else if (roll < 95) n = $urandom_range(11, MAX_FIELD_CHARS);
    else n = $urandom_range(MAX_FIELD_CHARS + 1, MAX_FIELD_CHARS + 6);
    repeat (n) send_byte(field_char(), 1'b0, '0);
  endtask

  task automatic send_header();
    for (int i = 0; i < nmeagga_pkg::HDR_LEN; i++) send_byte(header_seq[i], 1'b0, '0);
  endtask

  task automatic send_skip_byte();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 90) c = nmeagga_pkg::CHAR_COMMA;
    else c = field_char();
    send_byte(c, 1'b0, '0);
  endtask

  task automatic send_random_sentence();
    int kind;
    int cut;
    int nf;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_header();
      send_skip_byte();
      for (int f = 0; f < NUM_FIELDS; f++) begin
        send_field(f);
        send_byte(nmeagga_pkg::CHAR_COMMA, 1'b0, '0);
      end
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(1, 5)) send_byte(field_char(), 1'b0, '0);
      end
      send_byte(nmeagga_pkg::CHAR_NEWLINE, 1'b0, '0);
    end else if (kind < 85) begin
      // The sentence is cut short by a newline.
      send_header();
      cut = $urandom_range(0, 3);
      if (cut != 0) begin
        send_skip_byte();
        nf = $urandom_range(0, NUM_FIELDS - 1);
        for (int f = 0; f < nf; f++) begin
          send_field(f);
          send_byte(nmeagga_pkg::CHAR_COMMA, 1'b0, '0);
        end
        if (cut >= 2) send_field(nf);
      end
      send_byte(nmeagga_pkg::CHAR_NEWLINE, 1'b0, '0);
    end else if (kind < 93) begin
      nf = $urandom_range(0, nmeagga_pkg::HDR_LEN - 1);
      for (int i = 0; i < nf; i++) send_byte(header_seq[i], 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    nmeagga_pkg::result_t w;
    bit                   mid_drained;
    mid_drained = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      w = '0;
      w.sentence_done = dir_rows[i].done;
      w.lock          = dir_rows[i].lock;
      w.hour          = dir_rows[i].hour;
      w.minute        = dir_rows[i].minute;
      w.second        = dir_rows[i].second;
      send_byte(dir_rows[i].rx, dir_rows[i].typed, w);
    end
    in_tvalid <= 1'b0;
    wait_drained();
    while (bytes_sent < RANDOM_BYTES) begin
      if (!mid_drained && bytes_sent >= RANDOM_BYTES / 2) begin
        in_tvalid <= 1'b0;
        wait_drained();
        mid_drained = 1'b1;
      end
      send_random_sentence();
    end
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin : result_monitor
    nmeagga_pkg::result_t got;
    nmeagga_pkg::result_t want;
    int                   roll;
    if (rst_n && out_tvalid && out_tready) begin
      got.char_valid    = out_tuser;
      got.field_index   = out_tdata[3:0];
      got.char_position = out_tdata[7:4];
      got.character     = out_tdata[15:8];
      got.sentence_done = out_tlast;
      got.lock          = out_tdata[16];
      got.hour          = out_tdata[29:17];
      got.minute        = out_tdata[42:30];
      got.second        = out_tdata[55:43];
      if (pending_words.size() == 0) begin
        flag_mismatch("word with nothing pending", 0, 0);
      end else begin
        want = pending_words.pop_front();
        if (got.char_valid != want.char_valid)
          flag_mismatch("char_valid", got.char_valid, want.char_valid);
        if (got.field_index != want.field_index)
          flag_mismatch("field_index", got.field_index, want.field_index);
        if (got.char_position != want.char_position)
          flag_mismatch("char_position", got.char_position, want.char_position);
        if (got.character != want.character)
          flag_mismatch("character", got.character, want.character);
        if (got.sentence_done != want.sentence_done)
          flag_mismatch("sentence_done", got.sentence_done, want.sentence_done);
        if (got.lock != want.lock)
          flag_mismatch("lock", got.lock, want.lock);
        if (got.hour != want.hour)
          flag_mismatch("hour", got.hour, want.hour);
        if (got.minute != want.minute)
          flag_mismatch("minute", got.minute, want.minute);
        if (got.second != want.second)
          flag_mismatch("second", got.second, want.second);
      end
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else if (rx_calm_left > 0) begin
      rx_calm_left--;
      out_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        rx_calm_left = $urandom_range(20, 80);
        out_tready <= 1'b1;
      end else if (roll < 6) begin
        rx_stall_left = $urandom_range(10, 40);
        out_tready <= 1'b0;
      end else begin
        out_tready <= (roll >= 30);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/nmeagga_pkg.sv
hw/rtl/nmeagga_core.sv
hw/rtl/nmeagga_out_stage.sv
hw/rtl/nmea_gga_sentence_parser.sv
tb/nmea_gga_sentence_parser_test.sv
